// ===== src/mke_pkg.sv =====
// shared types, widths and constants of the matern kernel evaluator
package mke_pkg;

  localparam int DIST_FRAC_BITS_DEF = 16;

  localparam int DIST_W   = 32;
  localparam int TAU_W    = 24;
  localparam int ORDER_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int VALUE_W  = 32;

  // root width holds for every fraction width from 8 up
  localparam int X_W  = 28;
  localparam int S_W  = 30;
  localparam int A_W  = 22;
  localparam int A2_W = 28;
  localparam int E_W  = 33;
  localparam int Q_W  = 7;

  localparam logic [TAU_W-1:0] TAU_RESET = 24'd65536;

  localparam logic [25:0] SQRT3_Q24 = 26'd29058991;
  localparam logic [25:0] SQRT5_Q24 = 26'd37514995;
  localparam logic [15:0] LN2_Q16   = 16'd45426;
  localparam logic [16:0] LN2_RECIP = 17'd94548;         // floor(2^32 / ln2_q16)
  localparam logic [30:0] DIV3_RECIP32 = 31'd1431655765; // floor(2^32 / 3)
  localparam logic [32:0] DIV3_RECIP34 = 33'd5726623061; // floor(2^34 / 3)
  localparam logic [46:0] DIV3_SAT_LIMIT = 47'd6442450947; // 3 * (2^31 + 1)
  localparam logic [1:0]  DIV3 = 2'd3;
  localparam int EXP_TERMS = 12;
  localparam logic [Q_W-1:0] EXP_Q_MAX = 7'd33;

  // floor(2^32 / k) for the series terms
  localparam logic [31:0] EXP_RECIP [EXP_TERMS+1] = '{
    32'd0, 32'd0, 32'd2147483648, 32'd1431655765, 32'd1073741824,
    32'd858993459, 32'd715827882, 32'd613566756, 32'd536870912,
    32'd477218588, 32'd429496729, 32'd390451572, 32'd357913941
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAU          = 2'd0,
    CFG_KERNEL_ORDER = 2'd1,
    CFG_DERIV_MODE   = 2'd2
  } mke_cfg_idx_t;

  typedef enum logic [ORDER_W-1:0] {
    ORDER_HALF         = 2'd0,
    ORDER_THREE_HALVES = 2'd1,
    ORDER_FIVE_HALVES  = 2'd2
  } mke_order_t;

  // per-element data that rides alongside the exponential unit
  typedef struct packed {
    logic            last;
    logic            big;
    logic [S_W-1:0]  s;
    logic [A_W-1:0]  a;
    logic [A2_W-1:0] a2;
  } mke_side_t;

endpackage

// ===== src/mke_in_if.sv =====
// input channel: squared distance stream
interface mke_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dist_sqrd;
  logic        last_in;

  modport source (output valid, output dist_sqrd, output last_in, input ready);
  modport sink (input valid, input dist_sqrd, input last_in, output ready);
endinterface

// ===== src/mke_out_if.sv =====
// result channel: kernel values
interface mke_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] kernel_value;
  logic               last_out;

  modport source (output valid, output kernel_value, output last_out, input ready);
  modport sink (input valid, input kernel_value, input last_out, output ready);
endinterface

// ===== src/mke_sqrt.sv =====
// pipelined bit-serial square root, one result bit per stage
module mke_sqrt #(
  parameter int DIST_FRAC_BITS = mke_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [mke_pkg::DIST_W-1:0] in_dist,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic [mke_pkg::X_W-1:0]  out_x,
  output logic                     out_last
);

  localparam int STEPS = 32;
  localparam int SHIFT = 32 - DIST_FRAC_BITS;

  logic [63:0] v_r   [STEPS-1];
  logic [63:0] res_r [STEPS];
  logic        vld_r [STEPS];
  logic        last_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] v_in;
    logic [63:0] res_in;
    logic        vld_in;
    logic        last_in;
    logic [63:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign v_in    = 64'(in_dist) << SHIFT;
      assign res_in  = '0;
      assign vld_in  = in_valid;
      assign last_in = in_last;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign res_in  = res_r[i-1];
      assign vld_in  = vld_r[i-1];
      assign last_in = last_r[i-1];
    end

    assign trial = res_in + BIT;
    assign take  = (v_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        last_r[i] <= last_in;
        res_r[i]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
      end
    end

    if (i < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[i] <= take ? (v_in - trial) : v_in;
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_x     = res_r[STEPS-1][mke_pkg::X_W-1:0];
  assign out_last  = last_r[STEPS-1];

endmodule

// ===== src/mke_exp.sv =====
// pipelined e^-a in Q.32: ln2 range reduction and a 12-term series
module mke_exp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  mke_pkg::mke_side_t     in_side,
  output logic                   out_valid,
  output logic [mke_pkg::E_W-1:0] out_e,
  output mke_pkg::mke_side_t     out_side
);

  localparam int NT = mke_pkg::EXP_TERMS;

  typedef struct packed {
    logic [31:0]                r32;
    logic [mke_pkg::Q_W-1:0]    q;
    logic signed [33:0]         sum;
    mke_pkg::mke_side_t         side;
  } ctx_t;

  // quotient estimate by reciprocal, at most one low
  logic [38:0]              prod0;
  logic                     v0_r;
  mke_pkg::mke_side_t       side0_r;
  logic [mke_pkg::Q_W-1:0]  qe0_r;

  assign prod0 = 39'(in_side.a) * 39'(mke_pkg::LN2_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0_r <= in_side;
      qe0_r   <= prod0[38:32];
    end
  end

  // chain of series terms, index k holds the state after term k
  logic        v_c [1:NT];
  ctx_t        c_c [1:NT];
  logic [31:0] t_c [1:NT];

  logic [22:0]             rem1;
  logic                    fix1;
  logic [15:0]             r1;
  ctx_t                    ctx1_nxt;

  assign rem1 = 23'(side0_r.a) - 23'(qe0_r) * 23'(mke_pkg::LN2_Q16);
  assign fix1 = (rem1 >= 23'(mke_pkg::LN2_Q16));
  assign r1   = fix1 ? 16'(rem1 - 23'(mke_pkg::LN2_Q16)) : rem1[15:0];

  always_comb begin
    ctx1_nxt.r32  = {r1, 16'd0};
    ctx1_nxt.q    = fix1 ? (qe0_r + 7'd1) : qe0_r;
    ctx1_nxt.sum  = 34'sh1_0000_0000 - $signed({2'b00, r1, 16'd0});
    ctx1_nxt.side = side0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c[1] <= 1'b0;
    end else if (en) begin
      v_c[1] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_c[1] <= ctx1_nxt;
      t_c[1] <= {r1, 16'd0};
    end
  end

  for (genvar k = 2; k <= NT; k++) begin : g_term
    localparam logic [3:0] KV = 4'(k);
    logic [63:0] prod_a;
    logic [63:0] prod_b;
    logic [35:0] rem;
    logic [31:0] t_nxt;
    ctx_t        ctx_nxt;
    logic        va_r;
    ctx_t        ca_r;
    logic [31:0] pa_r;
    logic        vb_r;
    ctx_t        cb_r;
    logic [31:0] pb_r;
    logic [31:0] qb_r;

    assign prod_a = 64'(t_c[k-1]) * 64'(c_c[k-1].r32);
    assign prod_b = 64'(pa_r) * 64'(mke_pkg::EXP_RECIP[k]);
    assign rem    = 36'(pb_r) - 36'(qb_r) * 36'(KV);
    assign t_nxt  = (rem >= 36'(KV)) ? (qb_r + 32'd1) : qb_r;

    always_comb begin
      ctx_nxt = cb_r;
      if (k % 2 == 1) begin
        ctx_nxt.sum = cb_r.sum - $signed({2'b00, t_nxt});
      end else begin
        ctx_nxt.sum = cb_r.sum + $signed({2'b00, t_nxt});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r   <= 1'b0;
        vb_r   <= 1'b0;
        v_c[k] <= 1'b0;
      end else if (en) begin
        va_r   <= v_c[k-1];
        vb_r   <= va_r;
        v_c[k] <= vb_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ca_r   <= c_c[k-1];
        pa_r   <= prod_a[63:32];
        cb_r   <= ca_r;
        pb_r   <= pa_r;
        qb_r   <= prod_b[63:32];
        c_c[k] <= ctx_nxt;
        t_c[k] <= t_nxt;
      end
    end
  end

  // final scale by 2^-q, clamp of a negative sum, deep exponent flush
  logic [32:0]               sum_pos;
  logic [mke_pkg::E_W-1:0]   e_nxt;
  logic                      ve_r;
  logic [mke_pkg::E_W-1:0]   e_r;
  mke_pkg::mke_side_t        side_e_r;

  assign sum_pos = c_c[NT].sum[33] ? 33'd0 : c_c[NT].sum[32:0];
  assign e_nxt   = (c_c[NT].q >= mke_pkg::EXP_Q_MAX) ? '0 : (sum_pos >> c_c[NT].q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= v_c[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r      <= e_nxt;
      side_e_r <= c_c[NT].side;
    end
  end

  assign out_valid = ve_r;
  assign out_e     = e_r;
  assign out_side  = side_e_r;

  a_e_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ve_r |-> (e_r <= 33'h1_0000_0000))
    else $error("exp result above one");

endmodule

// ===== src/matern_kernel_eval_unit.sv =====
// matern covariance kernel evaluator, top level
// pipeline from input transfer to result valid: 32 root stages, 3 scaling stages,
//   36 exponential stages, 5 combine and output stages
// throughput: one element per cycle; a stalled output freezes the whole pipe
// reset: synchronous active-low rst_n clears all valid bits and sets tau to
//   1.0, order to nu 1/2 and derivative mode off; payload registers keep data
module matern_kernel_eval_unit #(
  parameter int DIST_FRAC_BITS = mke_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mke_in_if.sink                        in_ch,
  mke_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mke_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mke_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [mke_pkg::TAU_W-1:0]   tau_r;
  logic [mke_pkg::ORDER_W-1:0] order_r;
  logic                        deriv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tau_r   <= mke_pkg::TAU_RESET;
      order_r <= mke_pkg::ORDER_HALF;
      deriv_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (mke_pkg::mke_cfg_idx_t'(cfg_idx))
        mke_pkg::CFG_TAU:          tau_r   <= cfg_wdata[mke_pkg::TAU_W-1:0];
        mke_pkg::CFG_KERNEL_ORDER: order_r <= cfg_wdata[mke_pkg::ORDER_W-1:0];
        mke_pkg::CFG_DERIV_MODE:   deriv_r <= cfg_wdata[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // unused order code behaves as nu 5/2
  logic is0;
  logic is1;
  logic is2;
  assign is0 = (order_r == mke_pkg::ORDER_HALF);
  assign is1 = (order_r == mke_pkg::ORDER_THREE_HALVES);
  assign is2 = !is0 && !is1;

  // global advance: the pipe moves unless a result sits untaken
  logic out_vld_r;
  logic en;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // x = sqrt(d)
  logic                    vx;
  logic [mke_pkg::X_W-1:0] x;
  logic                    lastx;

  mke_sqrt #(.DIST_FRAC_BITS(DIST_FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_dist  (in_ch.dist_sqrd),
    .in_last  (in_ch.last_in),
    .out_valid(vx),
    .out_x    (x),
    .out_last (lastx)
  );

  // stage a: s = x * c for the higher orders
  logic [53:0]             prod_s;
  logic                    va_r;
  logic                    lasta_r;
  logic [mke_pkg::S_W-1:0] sa_r;

  assign prod_s = 54'(x) * 54'(is1 ? mke_pkg::SQRT3_Q24 : mke_pkg::SQRT5_Q24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lasta_r <= lastx;
      sa_r    <= is0 ? mke_pkg::S_W'(x) : prod_s[53:24];
    end
  end

  // stage b: a = tau * s, with the large-argument flag
  logic [53:0]             prod_a;
  logic                    vb_r;
  logic                    lastb_r;
  logic                    bigb_r;
  logic [mke_pkg::S_W-1:0] sb_r;
  logic [mke_pkg::A_W-1:0] ab_r;

  assign prod_a = 54'(tau_r) * 54'(sa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lastb_r <= lasta_r;
      bigb_r  <= |prod_a[53:38];
      sb_r    <= sa_r;
      ab_r    <= prod_a[37:16];
    end
  end

  // stage c: a2 = a * a
  logic [43:0]        prod_a2;
  logic               vc_r;
  mke_pkg::mke_side_t sidec_r;

  assign prod_a2 = 44'(ab_r) * 44'(ab_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sidec_r.last <= lastb_r;
      sidec_r.big  <= bigb_r;
      sidec_r.s    <= sb_r;
      sidec_r.a    <= ab_r;
      sidec_r.a2   <= prod_a2[43:16];
    end
  end

  // exponential
  logic                    ve;
  logic [mke_pkg::E_W-1:0] e;
  mke_pkg::mke_side_t      sidee;

  mke_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vc_r),
    .in_side  (sidec_r),
    .out_valid(ve),
    .out_e    (e),
    .out_side (sidee)
  );

  // stage d: g = s * e and a2 / 3 estimate
  logic [62:0]             prod_g;
  logic [58:0]             prod_q3;
  logic                    vd_r;
  mke_pkg::mke_side_t      sided_r;
  logic [mke_pkg::E_W-1:0] ed_r;
  logic [29:0]             gd_r;
  logic [26:0]             q3d_r;

  assign prod_g  = 63'(sidee.s) * 63'(e);
  assign prod_q3 = 59'(sidee.a2) * 59'(mke_pkg::DIV3_RECIP32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r <= sidee;
      ed_r    <= e;
      gd_r    <= prod_g[61:32];
      q3d_r   <= prod_q3[58:32];
    end
  end

  // stage f: polynomial factor and multiplier operand select
  logic [29:0] rem3;
  logic [26:0] a2d3;
  logic [28:0] poly;
  logic [28:0] dfac;
  logic        vf_r;
  logic        lastf_r;
  logic        bigf_r;
  logic [29:0] mxf_r;
  logic [32:0] myf_r;

  assign rem3 = 30'(sided_r.a2) - 30'(q3d_r) * 30'(mke_pkg::DIV3);
  assign a2d3 = (rem3 >= 30'(mke_pkg::DIV3)) ? (q3d_r + 27'd1) : q3d_r;
  assign poly = 29'h1_0000 + (is0 ? 29'd0 : 29'(sided_r.a)) + (is2 ? 29'(a2d3) : 29'd0);
  assign dfac = is1 ? 29'(sided_r.a) : (29'(sided_r.a) + 29'(sided_r.a2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lastf_r <= sided_r.last;
      bigf_r  <= sided_r.big;
      mxf_r   <= deriv_r ? gd_r : 30'(poly);
      myf_r   <= deriv_r ? (is0 ? 33'h1_0000 : 33'(dfac)) : ed_r;
    end
  end

  // stage g: shared product, p * e for the kernel or g * factor for d/dtau
  logic [62:0] prod_m;
  logic        vg_r;
  logic        lastg_r;
  logic        bigg_r;
  logic [62:0] pg_r;

  assign prod_m = 63'(mxf_r) * 63'(myf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (en) begin
      vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lastg_r <= lastf_r;
      bigg_r  <= bigf_r;
      pg_r    <= prod_m;
    end
  end

  // stage h: divide by three estimate for the nu 5/2 derivative
  logic [65:0] prod_d3;
  logic        vh_r;
  logic        lasth_r;
  logic        bigh_r;
  logic [62:0] ph_r;
  logic        sat3h_r;
  logic [31:0] qe3h_r;

  assign prod_d3 = 66'(pg_r[48:16]) * 66'(mke_pkg::DIV3_RECIP34);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
    end else if (en) begin
      vh_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lasth_r <= lastg_r;
      bigh_r  <= bigg_r;
      ph_r    <= pg_r;
      sat3h_r <= (pg_r[62:16] >= mke_pkg::DIV3_SAT_LIMIT);
      qe3h_r  <= prod_d3[65:34];
    end
  end

  // output stage: correction, negate, saturate
  logic [34:0]               rem_d3;
  logic [32:0]               m3;
  logic [32:0]               msel;
  logic                      msat;
  logic [32:0]               mneg;
  logic [mke_pkg::VALUE_W-1:0] value_nxt;
  logic [mke_pkg::VALUE_W-1:0] value_r;
  logic                      last_out_r;

  assign rem_d3 = 35'(ph_r[48:16]) - 35'(qe3h_r) * 35'(mke_pkg::DIV3);
  assign m3     = 33'(qe3h_r) + ((rem_d3 >= 35'(mke_pkg::DIV3)) ? 33'd1 : 33'd0);
  assign msel   = is2 ? m3 : ph_r[48:16];
  assign msat   = is2 ? sat3h_r : (ph_r[62:16] > 47'h8000_0000);
  assign mneg   = 33'd0 - msel;

  always_comb begin
    priority if (bigh_r) begin
      value_nxt = '0;
    end else if (!deriv_r) begin
      // kernel product is below 2^63, so the high word never overflows
      value_nxt = {1'b0, ph_r[62:32]};
    end else if (msat) begin
      value_nxt = 32'h8000_0000;
    end else begin
      value_nxt = mneg[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r    <= value_nxt;
      last_out_r <= lasth_r;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.kernel_value = value_r;
  assign out_ch.last_out     = last_out_r;

  // large argument always yields zero
  a_big_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vh_r && bigh_r) |=> (out_ch.kernel_value == 32'sd0))
    else $error("large argument gave nonzero value");

  // kernel values are never negative
  a_kernel_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !deriv_r) |-> !out_ch.kernel_value[31])
    else $error("negative kernel value");

  // derivative values are never positive
  a_deriv_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && deriv_r) |-> (out_ch.kernel_value[31] || out_ch.kernel_value == 32'sd0))
    else $error("positive derivative value");

endmodule

// ===== tb/sv/matern_kernel_eval_unit_tb.sv =====
// self-checking testbench for the matern kernel evaluator: directed and random streams
`timescale 1ns / 1ps

module matern_kernel_eval_unit_tb;

  // kernel_order code with no own meaning, behaves like nu 5/2
  localparam logic [mke_pkg::ORDER_W-1:0]   ORDER_SPARE = 2'd3;
  // register index that maps to nothing
  localparam logic [mke_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int  PIPE_LATENCY = 76;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam longint unsigned ARG_LIMIT = 64'd1 << 22;

  typedef struct {
    logic signed [mke_pkg::VALUE_W-1:0] value;
    logic                               last;
  } kernel_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mke_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mke_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mke_in_if  in_ch ();
  mke_out_if out_ch ();

  matern_kernel_eval_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow copy of the configuration registers
  logic [mke_pkg::TAU_W-1:0]   tau_q;
  logic [mke_pkg::ORDER_W-1:0] order_q;
  logic                        deriv_q;

  kernel_result_t pending_results[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_checked;
  int items_sent;
  int config_writes;
  int cycle_count = 0;

  // bit-serial integer square root of a 64-bit value
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // e^-a with a in Q.16, result in Q.32; range reduction by ln2 then taylor series
  function automatic longint unsigned exp_neg_q32(longint unsigned a);
    longint unsigned q;
    longint unsigned r32;
    longint unsigned term;
    longint sum;
    q = a / mke_pkg::LN2_Q16;
    if (q >= mke_pkg::EXP_Q_MAX) return 0;
    r32  = (a - q * mke_pkg::LN2_Q16) << 16;
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (int k = 1; k <= mke_pkg::EXP_TERMS; k++) begin
      term = ((term * r32) >> 32) / k;
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(unsigned'(sum)) >> q;
  endfunction

  // expected covariance or tau derivative for one squared distance
  function automatic logic signed [mke_pkg::VALUE_W-1:0] predict_kernel_value(
      logic [mke_pkg::DIST_W-1:0] dsq);
    longint unsigned x, s, a, a2, e, p, k, g, m;
    logic [mke_pkg::ORDER_W-1:0] ord;
    longint val;
    ord = (order_q == ORDER_SPARE) ? mke_pkg::ORDER_FIVE_HALVES : order_q;
    x = int_sqrt(longint'(dsq) << (32 - mke_pkg::DIST_FRAC_BITS_DEF));
    case (ord)
      mke_pkg::ORDER_HALF:         s = x;
      mke_pkg::ORDER_THREE_HALVES: s = (x * mke_pkg::SQRT3_Q24) >> 24;
      default:                     s = (x * mke_pkg::SQRT5_Q24) >> 24;
    endcase
    a   = (longint'(tau_q) * s) >> 16;
    val = 0;
    // large argument: the value underflows to zero in both modes
    if (a < ARG_LIMIT) begin
      e  = exp_neg_q32(a);
      a2 = (a * a) >> 16;
      if (!deriv_q) begin
        p = 64'd1 << 16;
        if (ord != mke_pkg::ORDER_HALF) p = p + a;
        if (ord == mke_pkg::ORDER_FIVE_HALVES) p = p + a2 / 3;
        k   = (p * e) >> 32;
        val = (k > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(k);
      end else begin
        g = (s * e) >> 32;
        case (ord)
          mke_pkg::ORDER_HALF:         m = g;
          mke_pkg::ORDER_THREE_HALVES: m = (g * a) >> 16;
          default:                     m = ((g * (a + a2)) >> 16) / 3;
        endcase
        val = (m > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(m);
      end
    end
    return val[mke_pkg::VALUE_W-1:0];
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random backpressure and compare against the oldest expectation
  always @(posedge clk) begin
    kernel_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result transfer: value %h last %b",
                   out_ch.kernel_value, out_ch.last_out);
      end else begin
        exp_r = pending_results.pop_front();
        results_checked = results_checked + 1;
        if (out_ch.kernel_value !== exp_r.value || out_ch.last_out !== exp_r.last) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch on result %0d: expected value %h last %b, got %h last %b",
                     results_checked, exp_r.value, exp_r.last,
                     out_ch.kernel_value, out_ch.last_out);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one input transfer; valid stays high afterwards so back-to-back items need no gap
  task automatic send_dist(logic [mke_pkg::DIST_W-1:0] dsq, logic last);
    kernel_result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.dist_sqrd <= dsq;
    in_ch.last_in   <= last;
    r.value = predict_kernel_value(dsq);
    r.last  = last;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(r);
    items_sent = items_sent + 1;
  endtask

  // hold off the sender until every expected result is back, then let the pipe empty
  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
  endtask

  // register write; only called while the pipe is empty
  task automatic write_reg(logic [mke_pkg::CFG_IDX_W-1:0] idx,
                           logic [mke_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mke_pkg::CFG_TAU:          tau_q   = data[mke_pkg::TAU_W-1:0];
      mke_pkg::CFG_KERNEL_ORDER: order_q = data[mke_pkg::ORDER_W-1:0];
      mke_pkg::CFG_DERIV_MODE:   deriv_q = data[0];
      default: ;
    endcase
    config_writes = config_writes + 1;
  endtask

  // random squared distance; shifted values keep many arguments below the underflow limit
  function automatic logic [mke_pkg::DIST_W-1:0] rand_dist();
    logic [mke_pkg::DIST_W-1:0] d;
    d = $urandom;
    if ($urandom_range(3) != 0) d = d >> $urandom_range(31);
    return d;
  endfunction

  function automatic logic [mke_pkg::CFG_DATA_W-1:0] rand_tau();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return {mke_pkg::TAU_W{1'b1}};
    return mke_pkg::CFG_DATA_W'($urandom) >> $urandom_range(12);
  endfunction

  // reset values: tau 1.0, nu 1/2, kernel value mode
  task automatic test_reset_defaults();
    send_dist(32'h0000_0000, 1'b0);
    send_dist(32'h0000_0001, 1'b0);
    send_dist(32'h0001_0000, 1'b0);
    send_dist(32'h0004_0000, 1'b0);
    send_dist(32'h8000_0000, 1'b0);
    send_dist(32'hFFFF_FFFF, 1'b1);
    drain_pipe();
  endtask

  // every order and both modes, extreme tau, the spare order code and the dead index
  task automatic test_orders_and_modes();
    write_reg(mke_pkg::CFG_TAU, {mke_pkg::TAU_W{1'b1}});
    write_reg(mke_pkg::CFG_KERNEL_ORDER, mke_pkg::CFG_DATA_W'(mke_pkg::ORDER_THREE_HALVES));
    write_reg(mke_pkg::CFG_DERIV_MODE, mke_pkg::CFG_DATA_W'(1));
    send_dist(32'h0000_0000, 1'b1);
    send_dist(32'h0000_0003, 1'b0);
    send_dist(32'h0000_0100, 1'b1);
    drain_pipe();
    write_reg(mke_pkg::CFG_TAU, 24'h02_0000);
    write_reg(mke_pkg::CFG_KERNEL_ORDER, mke_pkg::CFG_DATA_W'(ORDER_SPARE));
    write_reg(mke_pkg::CFG_DERIV_MODE, mke_pkg::CFG_DATA_W'(0));
    send_dist(32'h0000_8000, 1'b0);
    send_dist(32'h0010_0000, 1'b0);
    send_dist(32'h5555_5555, 1'b1);
    drain_pipe();
    // nu 5/2 derivative at tau 2.0, plus a write to the unused register index
    write_reg(mke_pkg::CFG_KERNEL_ORDER, mke_pkg::CFG_DATA_W'(mke_pkg::ORDER_FIVE_HALVES));
    write_reg(mke_pkg::CFG_DERIV_MODE, mke_pkg::CFG_DATA_W'(1));
    write_reg(CFG_UNUSED, {mke_pkg::CFG_DATA_W{1'b1}});
    send_dist(32'h0000_4000, 1'b0);
    send_dist(32'h0100_0000, 1'b0);
    drain_pipe();
    write_reg(mke_pkg::CFG_TAU, '0);
    write_reg(mke_pkg::CFG_KERNEL_ORDER, mke_pkg::CFG_DATA_W'(mke_pkg::ORDER_HALF));
    send_dist(32'hFFFF_FFFF, 1'b1);
    send_dist(32'h0000_0001, 1'b0);
    drain_pipe();
  endtask

  // random streams under one idle profile, new settings every block of items
  task automatic test_random_stream(int snd_pct, int rcv_pct, int blocks);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int b = 0; b < blocks; b++) begin
      write_reg(mke_pkg::CFG_TAU, rand_tau());
      write_reg(mke_pkg::CFG_KERNEL_ORDER, mke_pkg::CFG_DATA_W'($urandom_range(3)));
      write_reg(mke_pkg::CFG_DERIV_MODE, mke_pkg::CFG_DATA_W'($urandom_range(1)));
      if ($urandom_range(7) == 0) write_reg(CFG_UNUSED, mke_pkg::CFG_DATA_W'($urandom));
      repeat (100) send_dist(rand_dist(), ($urandom_range(15) == 0));
      drain_pipe();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.dist_sqrd <= '0;
    in_ch.last_in   <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= mke_pkg::CFG_TAU;
    cfg_wdata       <= '0;
    tau_q           = mke_pkg::TAU_RESET;
    order_q         = mke_pkg::ORDER_HALF;
    deriv_q         = 1'b0;
    send_idle_pct   = 10;
    recv_idle_pct   = 62;
    mismatches      = 0;
    results_checked = 0;
    items_sent      = 0;
    config_writes   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_orders_and_modes();
    test_random_stream(10, 62, 5);
    test_random_stream(62, 10, 5);
    test_random_stream(0, 0, 5);

    $display("covered %0d elements and %0d register writes over all orders and both modes",
             items_sent, config_writes);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== matern_kernel_eval_unit.f =====
src/mke_pkg.sv
src/mke_in_if.sv
src/mke_out_if.sv
src/mke_sqrt.sv
src/mke_exp.sv
src/matern_kernel_eval_unit.sv
tb/sv/matern_kernel_eval_unit_tb.sv
